@@ rtl/lrgm_pkg.sv @@
// lrgm_pkg: sizes, codes, shared types and small helper functions of the
// lattice rod move engine. No dependencies; used by every rtl file.
package lrgm_pkg;

  localparam int MaxDim    = 16;
  localparam int CoordW    = $clog2(MaxDim);
  localparam int DimW      = CoordW + 1;
  localparam int NumRows   = MaxDim * MaxDim;
  localparam int RowAw     = 2 * CoordW;
  localparam int NumCells  = MaxDim * MaxDim * MaxDim;
  localparam int VolW      = $clog2(NumCells) + 1;
  localparam int MaxRods   = 4096;
  localparam int IdxW      = $clog2(MaxRods);
  localparam int CntW      = IdxW + 1;
  localparam int NumW      = CntW + 1;
  localparam int NumAxes   = 3;
  localparam int AxW       = 2;
  localparam int LstDepth  = NumAxes * MaxRods;
  localparam int LstAw     = $clog2(LstDepth);
  localparam int CellW     = 3 * CoordW;
  localparam int LenW      = 5;
  localparam int DrawW     = 16;
  localparam int FracW     = 16;
  localparam int PickW     = 31;
  localparam int ActW      = 32;
  localparam int TotW      = 32;
  localparam int CfgW      = 32;
  localparam int CfgIdxW   = 3;
  localparam int MulW      = 32;
  localparam int ProdW     = 64;
  localparam int DivCntW   = $clog2(PickW + 1);
  localparam int StatW     = 3;

  typedef enum logic [StatW-1:0] {
    ST_ADDED    = 3'd0,
    ST_DELETED  = 3'd1,
    ST_BLOCKED  = 3'd2,
    ST_REJECTED = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [AxW-1:0] {
    AX_Y = 2'd0,
    AX_X = 2'd1,
    AX_Z = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_BXY  = 3'd1,
    MUL_VOL  = 3'd2,
    MUL_P1   = 3'd3,
    MUL_P2   = 3'd4,
    MUL_P3   = 3'd5
  } mul_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BOX_X      = 3'd0,
    CFG_BOX_Y      = 3'd1,
    CFG_BOX_Z      = 3'd2,
    CFG_ROD_LENGTH = 3'd3,
    CFG_ACTIVITY   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [DimW-1:0] box_x;
    logic [DimW-1:0] box_y;
    logic [DimW-1:0] box_z;
    logic [LenW-1:0] rod_length;
    logic [ActW-1:0] activity;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_z;
    logic [1:0]        orient;
    logic [PickW-1:0]  pick_draw;
    logic [DrawW-1:0]  accept_draw;
  } item_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [CntW-1:0]  count_along_y;
    logic [CntW-1:0]  count_along_x;
    logic [CntW-1:0]  count_along_z;
    logic [TotW-1:0]  additions_total;
    logic [TotW-1:0]  deletions_total;
  } res_t;

  typedef struct packed {
    logic    load;
    mul_op_e mul;
    logic    fix;
    logic    walk_init;
    logic    walk_adv;
    logic    occ_rd;
    logic    occ_wr;
    logic    occ_val;
    logic    div_start;
    logic    div_step;
    logic    pick;
    logic    org_rd;
    logic    org_load;
    logic    sh_rd;
    logic    sh_wr;
    logic    push;
    logic    pop;
    logic    st_load;
    status_e st_code;
    logic    res_load;
    logic    clr_wr;
  } cmd_t;

  typedef struct packed {
    logic func_del;
    logic full;
    logic n_zero;
    logic le;
    logic occ_hit;
    logic walk_last;
    logic div_done;
    logic sh_done;
    logic clr_done;
    logic out_free;
  } stat_t;

  // zero acts as one, anything above the lattice size acts as the lattice size
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
    return r;
  endfunction

  // coordinate modulo extent, restoring form, one step per coordinate bit
  function automatic logic [CoordW-1:0] mod_dim(input logic [CoordW-1:0] v,
                                                input logic [DimW-1:0] b);
    logic [DimW-1:0] r;
    r = '0;
    for (int i = CoordW - 1; i >= 0; i--) begin
      r = {r[DimW-2:0], v[i]};
      if (r >= b) r = r - b;
    end
    return r[CoordW-1:0];
  endfunction

endpackage

@@ rtl/lrgm_if.sv @@
// lrgm_in_if / lrgm_out_if: valid-ready channels for move items and results.
// Depends on lrgm_pkg for field widths.
interface lrgm_in_if import lrgm_pkg::*;;
  logic              valid;
  logic              ready;
  logic              func;
  logic [CoordW-1:0] pos_x;
  logic [CoordW-1:0] pos_y;
  logic [CoordW-1:0] pos_z;
  logic [1:0]        orient;
  logic [PickW-1:0]  pick_draw;
  logic [DrawW-1:0]  accept_draw;

  modport source (output valid, func, pos_x, pos_y, pos_z, orient, pick_draw,
                  accept_draw, input ready);
  modport sink (input valid, func, pos_x, pos_y, pos_z, orient, pick_draw,
                accept_draw, output ready);
endinterface

interface lrgm_out_if import lrgm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [CntW-1:0]  count_along_y;
  logic [CntW-1:0]  count_along_x;
  logic [CntW-1:0]  count_along_z;
  logic [TotW-1:0]  additions_total;
  logic [TotW-1:0]  deletions_total;

  modport source (output valid, status, count_along_y, count_along_x,
                  count_along_z, additions_total, deletions_total, input ready);
  modport sink (input valid, status, count_along_y, count_along_x,
                count_along_z, additions_total, deletions_total, output ready);
endinterface

@@ rtl/lrgm_ctrl.sv @@
// lrgm_ctrl: move sequencer; issues datapath commands one state at a time.
// Depends on lrgm_pkg (cmd_t, stat_t, status codes).
module lrgm_ctrl import lrgm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [21:0] {
    S_CLEAR  = 22'd1 << 0,
    S_IDLE   = 22'd1 << 1,
    S_V1     = 22'd1 << 2,
    S_V2     = 22'd1 << 3,
    S_M1     = 22'd1 << 4,
    S_M2     = 22'd1 << 5,
    S_M3     = 22'd1 << 6,
    S_FIX    = 22'd1 << 7,
    S_BRANCH = 22'd1 << 8,
    S_CRD    = 22'd1 << 9,
    S_CCHK   = 22'd1 << 10,
    S_SRD    = 22'd1 << 11,
    S_SWR    = 22'd1 << 12,
    S_DIV    = 22'd1 << 13,
    S_PICK   = 22'd1 << 14,
    S_ORD    = 22'd1 << 15,
    S_OLD    = 22'd1 << 16,
    S_DRD    = 22'd1 << 17,
    S_DWR    = 22'd1 << 18,
    S_SH     = 22'd1 << 19,
    S_SHW    = 22'd1 << 20,
    S_FIN    = 22'd1 << 21
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mul  = MUL_NONE;
    cmd_o.st_code = ST_BLOCKED;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_V1;
        end
      end
      S_V1: begin
        cmd_o.mul = MUL_BXY;
        state_d   = S_V2;
      end
      S_V2: begin
        cmd_o.mul = MUL_VOL;
        state_d   = S_M1;
      end
      S_M1: begin
        cmd_o.mul = MUL_P1;
        state_d   = S_M2;
      end
      S_M2: begin
        cmd_o.mul = MUL_P2;
        state_d   = S_M3;
      end
      S_M3: begin
        cmd_o.mul = MUL_P3;
        state_d   = S_FIX;
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_BRANCH;
      end
      S_BRANCH: begin
        if (!stat_i.func_del) begin
          if (stat_i.full) begin
            cmd_o.st_load = 1'b1;
            cmd_o.st_code = ST_BLOCKED;
            state_d       = S_FIN;
          end else begin
            cmd_o.walk_init = 1'b1;
            state_d         = S_CRD;
          end
        end else if (stat_i.n_zero) begin
          cmd_o.st_load = 1'b1;
          cmd_o.st_code = ST_EMPTY;
          state_d       = S_FIN;
        end else if (!stat_i.le) begin
          cmd_o.st_load = 1'b1;
          cmd_o.st_code = ST_REJECTED;
          state_d       = S_FIN;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_CRD: begin
        cmd_o.occ_rd = 1'b1;
        state_d      = S_CCHK;
      end
      S_CCHK: begin
        if (stat_i.occ_hit) begin
          cmd_o.st_load = 1'b1;
          cmd_o.st_code = ST_BLOCKED;
          state_d       = S_FIN;
        end else if (stat_i.walk_last) begin
          if (!stat_i.le) begin
            cmd_o.st_load = 1'b1;
            cmd_o.st_code = ST_REJECTED;
            state_d       = S_FIN;
          end else begin
            cmd_o.walk_init = 1'b1;
            state_d         = S_SRD;
          end
        end else begin
          cmd_o.walk_adv = 1'b1;
          state_d        = S_CRD;
        end
      end
      S_SRD: begin
        cmd_o.occ_rd = 1'b1;
        state_d      = S_SWR;
      end
      S_SWR: begin
        cmd_o.occ_wr  = 1'b1;
        cmd_o.occ_val = 1'b1;
        if (stat_i.walk_last) begin
          cmd_o.push    = 1'b1;
          cmd_o.st_load = 1'b1;
          cmd_o.st_code = ST_ADDED;
          state_d       = S_FIN;
        end else begin
          cmd_o.walk_adv = 1'b1;
          state_d        = S_SRD;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = S_PICK;
        else cmd_o.div_step = 1'b1;
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = S_ORD;
      end
      S_ORD: begin
        cmd_o.org_rd = 1'b1;
        state_d      = S_OLD;
      end
      S_OLD: begin
        cmd_o.org_load = 1'b1;
        state_d        = S_DRD;
      end
      S_DRD: begin
        cmd_o.occ_rd = 1'b1;
        state_d      = S_DWR;
      end
      S_DWR: begin
        cmd_o.occ_wr = 1'b1;
        if (stat_i.walk_last) begin
          state_d = S_SH;
        end else begin
          cmd_o.walk_adv = 1'b1;
          state_d        = S_DRD;
        end
      end
      S_SH: begin
        if (stat_i.sh_done) begin
          cmd_o.pop     = 1'b1;
          cmd_o.st_load = 1'b1;
          cmd_o.st_code = ST_DELETED;
          state_d       = S_FIN;
        end else begin
          cmd_o.sh_rd = 1'b1;
          state_d     = S_SHW;
        end
      end
      S_SHW: begin
        cmd_o.sh_wr = 1'b1;
        state_d     = S_SH;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/lrgm_datapath.sv @@
// lrgm_datapath: occupancy and rod-list memories, shared multiplier, remainder
// unit, cell walker, counters and result register. Depends on lrgm_pkg.
module lrgm_datapath import lrgm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  item_t item_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  res_o
);

  logic              func_del_q;
  logic [AxW-1:0]    ax_q;
  logic [CoordW-1:0] ox_q, oy_q, oz_q;
  logic [CoordW-1:0] cx_q, cy_q, cz_q;
  logic [LenW-1:0]   wi_q;
  logic [PickW-1:0]  pick_q;
  logic [DrawW-1:0]  draw_q;
  logic [DimW-1:0]   bx_q, by_q, bz_q;
  logic [LenW-1:0]   len_q;
  logic [ActW-1:0]   act_q;
  logic [NumW-1:0]   n_q;
  logic [VolW-1:0]   vol_q;
  logic [MulW-1:0]   r0_q;
  logic [ProdW-1:0]  lhs_q, rhs_q;
  logic [NumW-1:0]   rem_q;
  logic [PickW-1:0]  dsh_q;
  logic [DivCntW-1:0] dcnt_q;
  logic [IdxW-1:0]   k_q;
  logic [CntW-1:0]   j_q;
  logic [CntW-1:0]   cnt_q [NumAxes];
  logic [TotW-1:0]   add_tot_q, del_tot_q;
  logic [RowAw-1:0]  clr_q;
  status_e           st_q;
  logic              out_valid_q;
  res_t              res_q;

  logic [MaxDim-1:0] occ_mem [NumRows];
  logic [MaxDim-1:0] row_q;
  logic [MaxDim-1:0] wrow;
  logic [CellW-1:0]  lst_mem [LstDepth];
  logic [CellW-1:0]  lst_q;

  logic [NumW-1:0]   n_y, n_yx, pick_idx;
  logic [AxW-1:0]    pick_ax;

  // ---------------------------------------------------------------- load
  logic [DimW-1:0] bx_c, by_c, bz_c;
  assign bx_c = clamp_dim(cfg_i.box_x);
  assign by_c = clamp_dim(cfg_i.box_y);
  assign bz_c = clamp_dim(cfg_i.box_z);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_del_q <= item_i.func;
      ax_q       <= (item_i.orient == 2'd3) ? AX_Z : item_i.orient;
      bx_q       <= bx_c;
      by_q       <= by_c;
      bz_q       <= bz_c;
      ox_q       <= mod_dim(item_i.pos_x, bx_c);
      oy_q       <= mod_dim(item_i.pos_y, by_c);
      oz_q       <= mod_dim(item_i.pos_z, bz_c);
      len_q      <= (cfg_i.rod_length == '0) ? LenW'(1) : cfg_i.rod_length;
      act_q      <= cfg_i.activity;
      pick_q     <= item_i.pick_draw;
      draw_q     <= item_i.accept_draw;
      n_q        <= NumW'(cnt_q[0]) + NumW'(cnt_q[1]) + NumW'(cnt_q[2]);
    end else if (cmd_i.pick) begin
      ax_q <= pick_ax;
    end
  end

  // ---------------------------------------------------------- multiplier
  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul)
      MUL_BXY: begin
        mul_a = MulW'(bx_q);
        mul_b = MulW'(by_q);
      end
      MUL_VOL: begin
        mul_a = MulW'(vol_q);
        mul_b = MulW'(bz_q);
      end
      MUL_P1: begin
        mul_a = MulW'(draw_q);
        mul_b = func_del_q ? MulW'(vol_q) : MulW'(len_q);
      end
      MUL_P2: begin
        mul_a = r0_q;
        mul_b = func_del_q ? act_q : MulW'(n_q) + MulW'(1);
      end
      MUL_P3: begin
        mul_a = func_del_q ? MulW'(n_q) : act_q;
        mul_b = func_del_q ? MulW'(len_q) : MulW'(vol_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    case (cmd_i.mul)
      MUL_BXY, MUL_VOL: vol_q <= prod[VolW-1:0];
      MUL_P1:           r0_q  <= prod[MulW-1:0];
      MUL_P2:           lhs_q <= func_del_q ? prod : (prod << FracW);
      MUL_P3:           rhs_q <= prod;
      default: ;
    endcase
    // scale by the draw full-scale value, and by one in 16.16 for deletion
    if (cmd_i.fix) begin
      rhs_q <= func_del_q ? (rhs_q << (FracW + DrawW)) - (rhs_q << FracW)
                          : (rhs_q << DrawW) - rhs_q;
    end
  end

  // --------------------------------------------------------- cell walker
  logic [DimW-1:0]   bax;
  logic [CoordW-1:0] cax, cax_nx;
  logic [CoordW-1:0] lx, ly, lz;

  always_comb begin
    case (ax_q)
      AX_Y:    begin bax = by_q; cax = cy_q; end
      AX_X:    begin bax = bx_q; cax = cx_q; end
      default: begin bax = bz_q; cax = cz_q; end
    endcase
    cax_nx = (({1'b0, cax} + DimW'(1)) == bax) ? '0 : cax + CoordW'(1);
  end

  assign lx = lst_q[CoordW-1:0];
  assign ly = lst_q[2*CoordW-1:CoordW];
  assign lz = lst_q[3*CoordW-1:2*CoordW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      cx_q <= ox_q;
      cy_q <= oy_q;
      cz_q <= oz_q;
      wi_q <= '0;
    end else if (cmd_i.org_load) begin
      // only the axial coordinate is folded into the current box
      cx_q <= (ax_q == AX_X) ? mod_dim(lx, bx_q) : lx;
      cy_q <= (ax_q == AX_Y) ? mod_dim(ly, by_q) : ly;
      cz_q <= (ax_q == AX_Z) ? mod_dim(lz, bz_q) : lz;
      wi_q <= '0;
    end else if (cmd_i.walk_adv) begin
      wi_q <= wi_q + LenW'(1);
      case (ax_q)
        AX_Y:    cy_q <= cax_nx;
        AX_X:    cx_q <= cax_nx;
        default: cz_q <= cax_nx;
      endcase
    end
  end

  // ----------------------------------------------------- occupancy memory
  logic [RowAw-1:0] row_addr;
  assign row_addr = {cz_q, cy_q};

  always_comb begin
    wrow        = row_q;
    wrow[cx_q]  = cmd_i.occ_val;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      occ_mem[clr_q] <= '0;
    end else if (cmd_i.occ_wr) begin
      occ_mem[row_addr] <= wrow;
    end
    if (cmd_i.occ_rd) begin
      row_q <= occ_mem[row_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + RowAw'(1);
    end
  end

  // ------------------------------------------------------ remainder unit
  logic [NumW:0] trial;
  assign trial = {rem_q, dsh_q[PickW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      dsh_q  <= pick_q;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= (trial >= {1'b0, n_q}) ? NumW'(trial - {1'b0, n_q}) : trial[NumW-1:0];
      dsh_q  <= dsh_q << 1;
      dcnt_q <= dcnt_q + DivCntW'(1);
    end
  end

  // ---------------------------------------------------- rod pick, lists
  always_comb begin
    n_y  = NumW'(cnt_q[0]);
    n_yx = NumW'(cnt_q[0]) + NumW'(cnt_q[1]);
    if (rem_q < n_y) begin
      pick_ax  = AX_Y;
      pick_idx = rem_q;
    end else if (rem_q < n_yx) begin
      pick_ax  = AX_X;
      pick_idx = rem_q - n_y;
    end else begin
      pick_ax  = AX_Z;
      pick_idx = rem_q - n_yx;
    end
  end

  logic [CntW-1:0] j_nx;
  assign j_nx = j_q + CntW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      k_q <= pick_idx[IdxW-1:0];
      j_q <= pick_idx[CntW-1:0];
    end else if (cmd_i.sh_wr) begin
      j_q <= j_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      lst_mem[{ax_q, cnt_q[ax_q][IdxW-1:0]}] <= {oz_q, oy_q, ox_q};
    end else if (cmd_i.sh_wr) begin
      lst_mem[{ax_q, j_q[IdxW-1:0]}] <= lst_q;
    end
    if (cmd_i.org_rd) begin
      lst_q <= lst_mem[{ax_q, k_q}];
    end else if (cmd_i.sh_rd) begin
      lst_q <= lst_mem[{ax_q, j_nx[IdxW-1:0]}];
    end
  end

  // ------------------------------------------------ counts and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAxes; i++) cnt_q[i] <= '0;
      add_tot_q <= '0;
      del_tot_q <= '0;
    end else if (cmd_i.push) begin
      cnt_q[ax_q] <= cnt_q[ax_q] + CntW'(1);
      if (add_tot_q != '1) add_tot_q <= add_tot_q + TotW'(1);
    end else if (cmd_i.pop) begin
      cnt_q[ax_q] <= cnt_q[ax_q] - CntW'(1);
      if (del_tot_q != '1) del_tot_q <= del_tot_q + TotW'(1);
    end
  end

  // ---------------------------------------------------- result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.st_load) st_q <= cmd_i.st_code;
    if (cmd_i.res_load) begin
      res_q.status          <= st_q;
      res_q.count_along_y   <= cnt_q[0];
      res_q.count_along_x   <= cnt_q[1];
      res_q.count_along_z   <= cnt_q[2];
      res_q.additions_total <= add_tot_q;
      res_q.deletions_total <= del_tot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // --------------------------------------------------------------- status
  assign stat_o.func_del  = func_del_q;
  assign stat_o.full      = cnt_q[ax_q] >= CntW'(MaxRods);
  assign stat_o.n_zero    = (n_q == '0);
  assign stat_o.le        = (lhs_q <= rhs_q);
  assign stat_o.occ_hit   = row_q[cx_q];
  assign stat_o.walk_last = ((wi_q + LenW'(1)) == len_q);
  assign stat_o.div_done  = (dcnt_q == DivCntW'(PickW));
  assign stat_o.sh_done   = (j_nx >= cnt_q[ax_q]);
  assign stat_o.clr_done  = (clr_q == RowAw'(NumRows - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // ----------------------------------------------------------- assertions
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CntW'(MaxRods)) && (cnt_q[1] <= CntW'(MaxRods)) &&
    (cnt_q[2] <= CntW'(MaxRods)))
    else $error("rod count above list depth");

  a_rem_below_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < n_q))
    else $error("partial remainder not below rod count");

  a_walk_in_rod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.occ_rd |-> (wi_q < len_q))
    else $error("cell walk beyond rod length");

  a_res_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |=> out_valid_q)
    else $error("result loaded but not presented");

endmodule

@@ rtl/lattice_rod_gcmc_move.sv @@
// lattice_rod_gcmc_move: top level; configuration registers, sequencer and
// datapath. Depends on lrgm_pkg, lrgm_if, lrgm_ctrl and lrgm_datapath.
//
//  channel   dir  handshake           beat
//  in_chan   in   valid/ready         one trial move (add or delete)
//  out_chan  out  valid/ready         status, rod counts, move totals
//  cfg       in   cfg_we_i            one register write, no back-pressure
//
// after reset the occupancy store is swept row by row before any beat is taken
// the length of an addition is set by the occupancy read-modify-write walk;
// that of a deletion by the 31-step remainder unit, the occupancy walk and
// the list shift over the rods after the picked one in its list
// one move at a time; a new beat is taken while the previous result waits
// a stalled result holds the block only once the next move has finished
module lattice_rod_gcmc_move import lrgm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  lrgm_in_if.sink            in_chan,
  lrgm_out_if.source         out_chan,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;
  item_t item;
  res_t  res;
  logic  in_ready;
  logic  out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_x      <= DimW'(MaxDim);
      cfg_q.box_y      <= DimW'(MaxDim);
      cfg_q.box_z      <= DimW'(MaxDim);
      cfg_q.rod_length <= LenW'(4);
      cfg_q.activity   <= ActW'(1) << FracW;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BOX_X:      cfg_q.box_x      <= cfg_wdata_i[DimW-1:0];
        CFG_BOX_Y:      cfg_q.box_y      <= cfg_wdata_i[DimW-1:0];
        CFG_BOX_Z:      cfg_q.box_z      <= cfg_wdata_i[DimW-1:0];
        CFG_ROD_LENGTH: cfg_q.rod_length <= cfg_wdata_i[LenW-1:0];
        CFG_ACTIVITY:   cfg_q.activity   <= cfg_wdata_i[ActW-1:0];
        default: ;
      endcase
    end
  end

  assign item.func        = in_chan.func;
  assign item.pos_x       = in_chan.pos_x;
  assign item.pos_y       = in_chan.pos_y;
  assign item.pos_z       = in_chan.pos_z;
  assign item.orient      = in_chan.orient;
  assign item.pick_draw   = in_chan.pick_draw;
  assign item.accept_draw = in_chan.accept_draw;
  assign in_chan.ready    = in_ready;

  lrgm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lrgm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (item),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid),
    .out_ready_i (out_chan.ready),
    .res_o       (res)
  );

  assign out_chan.valid           = out_valid;
  assign out_chan.status          = res.status;
  assign out_chan.count_along_y   = res.count_along_y;
  assign out_chan.count_along_x   = res.count_along_x;
  assign out_chan.count_along_z   = res.count_along_z;
  assign out_chan.additions_total = res.additions_total;
  assign out_chan.deletions_total = res.deletions_total;

endmodule
